FILE: design/bsfn_pkg.sv
// shared types and constants for the bitmap set with find-next unit
package bsfn_pkg;

    localparam int POS_W  = 9;
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;
    localparam int WIDX_W = POS_W - BIT_W;

    localparam logic [POS_W-1:0] CFG_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TEST   = 2'd2,
        OP_FIND   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       member;
        logic [POS_W-1:0] search_from;
    } t_in_word;

    typedef struct packed {
        logic             is_member;
        logic             found;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] member_count;
        logic             out_of_range;
    } t_out_word;

    typedef struct packed {
        logic [WIDX_W-1:0] widx;
        logic [POS_W-1:0]  from;
        logic [POS_W-1:0]  size;
    } t_scan_req;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] bit_idx;
        logic             exhausted;
    } t_scan_res;

endpackage

FILE: design/bsfn_ram.sv
// generic single-write, single-read ram with registered read data
module bsfn_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bsfn_scan.sv
// masks one bitmap word to the search window and finds its lowest set bit
module bsfn_scan (
    input  bsfn_pkg::t_scan_req           i_req,
    input  logic [bsfn_pkg::WORD_W-1:0]   i_data,
    output bsfn_pkg::t_scan_res           o_res
);
    import bsfn_pkg::*;

    logic [WIDX_W-1:0] size_w;
    logic [BIT_W-1:0]  size_b;
    logic [WIDX_W-1:0] from_w;
    logic [BIT_W-1:0]  from_b;
    logic [WORD_W-1:0] upper;
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] masked;
    logic [POS_W:0]    next_start;
    logic [BIT_W-1:0]  first;

    assign size_w = i_req.size[POS_W-1:BIT_W];
    assign size_b = i_req.size[BIT_W-1:0];
    assign from_w = i_req.from[POS_W-1:BIT_W];
    assign from_b = i_req.from[BIT_W-1:0];

    always_comb begin
        priority if (i_req.widx < size_w) begin
            upper = '1;
        end else if (i_req.widx == size_w) begin
            upper = ~({WORD_W{1'b1}} << size_b);
        end else begin
            upper = '0;
        end
        lower = (i_req.widx == from_w) ? ({WORD_W{1'b1}} << from_b) : '1;
        masked = i_data & upper & lower;
    end

    // lowest set bit wins
    always_comb begin
        first = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (masked[i]) begin
                first = BIT_W'(i);
            end
        end
    end

    assign next_start = {({1'b0, i_req.widx} + (WIDX_W + 1)'(1)), {BIT_W{1'b0}}};

    assign o_res.hit       = |masked;
    assign o_res.bit_idx   = first;
    assign o_res.exhausted = next_start >= {1'b0, i_req.size};

endmodule

FILE: design/bitmap_set_with_find_next_unit.sv
// top level of the bitmap set with find-next unit
//
//  channel  direction  handshake               payload
//  in       input      i_in_valid / o_in_stall  i_in_word  (t_in_word)
//  out      output     o_out_valid / i_out_stall o_out_word (t_out_word)
//  cfg      input      i_cfg_we                 i_cfg_wdata (members_in_use)
//
// insert, remove and test: accept with the word read, then for a member in range
// insert and remove do one read-modify-write on the bitmap ram, test only reads
// find: accept with the first word read, then scan the 32-bit bitmap words, one word
// per cycle through the single ram read port
// after reset a clearing pass writes zero to every bitmap word, one word per
// cycle, while the input stalls
// the output word sits in a register, so a stalled output holds the next
// request only at its final cycle, not at acceptance
module bitmap_set_with_find_next_unit #(
    parameter int SET_CAPACITY = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bsfn_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bsfn_pkg::t_out_word           o_out_word,
    input  logic                          i_cfg_we,
    input  logic [bsfn_pkg::POS_W-1:0]    i_cfg_wdata
);
    import bsfn_pkg::*;

    localparam int DEPTH  = (SET_CAPACITY + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // state registers
    t_state            r_state, n_state;
    t_in_word          r_req;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic [POS_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_cfg;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;

    // ram port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    // working signals
    logic [POS_W-1:0]  size;
    logic              accept;
    logic              can_out;
    logic [POS_W-1:0]  in_pos;
    logic [POS_W-1:0]  req_pos;
    logic              req_oor;
    logic [WORD_W-1:0] bit_mask;
    logic              cur_bit;
    t_scan_req         scan_req;
    t_scan_res         scan_res;

    // register value above the parameter acts as the parameter
    assign size = (32'(r_cfg) > SET_CAPACITY) ? POS_W'(SET_CAPACITY) : r_cfg;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign can_out     = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // position that selects the first word read for an accepted request
    assign in_pos  = (t_op'(i_in_word.operation) == OP_FIND) ? i_in_word.search_from
                                                             : {1'b0, i_in_word.member};
    assign req_pos = {1'b0, r_req.member};
    assign req_oor = req_pos >= size;

    assign bit_mask = WORD_W'(1) << req_pos[BIT_W-1:0];
    assign cur_bit  = |(mem_rdata & bit_mask);

    assign scan_req.widx = r_widx;
    assign scan_req.from = r_req.search_from;
    assign scan_req.size = size;

    bsfn_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bsfn_scan u_scan (
        .i_req  (scan_req),
        .i_data (mem_rdata),
        .o_res  (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_count     <= '0;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_clr_addr  <= n_clr_addr;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_word;
        end
        r_widx <= n_widx;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_widx      = r_widx;
        n_count     = r_count;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = ADDR_W'(r_widx);
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = ADDR_W'(in_pos[POS_W-1:BIT_W]);

        unique case (r_state)
            ST_CLEAR: begin
                // zero one bitmap word per cycle
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    mem_re  = 1'b1;
                    n_widx  = in_pos[POS_W-1:BIT_W];
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (t_op'(r_req.operation) == OP_FIND) begin
                    if (scan_res.hit || scan_res.exhausted) begin
                        if (can_out) begin
                            n_out_valid          = 1'b1;
                            n_out.is_member      = 1'b0;
                            n_out.found          = scan_res.hit;
                            n_out.found_position = scan_res.hit ?
                                                   {r_widx, scan_res.bit_idx} : size;
                            n_out.member_count   = r_count;
                            n_out.out_of_range   = 1'b0;
                            n_state              = ST_IDLE;
                        end
                    end else begin
                        // fetch the next word of the window
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(r_widx + WIDX_W'(1));
                        n_widx    = r_widx + WIDX_W'(1);
                    end
                end else if (can_out) begin
                    n_out_valid          = 1'b1;
                    n_out.is_member      = 1'b0;
                    n_out.found          = 1'b0;
                    n_out.found_position = '0;
                    n_out.out_of_range   = req_oor;
                    if (!req_oor) begin
                        unique case (t_op'(r_req.operation))
                            OP_INSERT: begin
                                mem_we    = 1'b1;
                                mem_wdata = mem_rdata | bit_mask;
                                if (!cur_bit) begin
                                    n_count = r_count + POS_W'(1);
                                end
                            end
                            OP_REMOVE: begin
                                mem_we    = 1'b1;
                                mem_wdata = mem_rdata & ~bit_mask;
                                if (cur_bit && (r_count != '0)) begin
                                    n_count = r_count - POS_W'(1);
                                end
                            end
                            default: begin
                                n_out.is_member = cur_bit;
                            end
                        endcase
                    end
                    n_out.member_count = n_count;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: tb/sv/bsfn_checker.sv
// scoreboard for the bitmap set unit: predicts every result word and compares it
module bsfn_checker #(
    parameter int SET_CAPACITY = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  bsfn_pkg::t_in_word           i_in_word,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  bsfn_pkg::t_out_word          i_out_word,
    input  logic                         i_cfg_we,
    input  logic [bsfn_pkg::POS_W-1:0]   i_cfg_wdata,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);
    import bsfn_pkg::*;

    localparam int SHOWN_FAILS = 10;

    bit [SET_CAPACITY-1:0] member_bits;
    bit [POS_W-1:0]        live_count;
    bit [POS_W-1:0]        size_reg;
    t_out_word             due_results[$];
    int                    fails;
    int                    checked;

    // register value saturated at the parameter
    function automatic int unsigned set_size();
        return (size_reg > SET_CAPACITY) ? SET_CAPACITY : size_reg;
    endfunction

    // updates the set for one request word and returns its result word
    function automatic t_out_word apply_request(t_in_word w);
        t_out_word   r;
        int unsigned lim;
        r   = '0;
        lim = set_size();
        if (w.operation == OP_FIND) begin
            r.found_position = lim[POS_W-1:0];
            for (int unsigned p = w.search_from; p < lim; p++) begin
                if (member_bits[p]) begin
                    r.found          = 1'b1;
                    r.found_position = p[POS_W-1:0];
                    break;
                end
            end
        end else if (w.member >= lim) begin
            r.out_of_range = 1'b1;
        end else begin
            case (w.operation)
                OP_INSERT: begin
                    if (!member_bits[w.member])
                        live_count++;
                    member_bits[w.member] = 1'b1;
                end
                OP_REMOVE: begin
                    if (member_bits[w.member] && live_count != 0)
                        live_count--;
                    member_bits[w.member] = 1'b0;
                end
                default: r.is_member = member_bits[w.member];
            endcase
        end
        r.member_count = live_count;
        return r;
    endfunction

    task automatic check_result(t_out_word got);
        t_out_word exp;
        checked++;
        if (due_results.size() == 0) begin
            fails++;
            if (fails <= SHOWN_FAILS)
                $display({"bsfn_checker: result word with none expected: ",
                          "mem=%0b found=%0b pos=%0d cnt=%0d oor=%0b"},
                         got.is_member, got.found, got.found_position,
                         got.member_count, got.out_of_range);
            return;
        end
        exp = due_results.pop_front();
        if (got.is_member !== exp.is_member || got.found !== exp.found
            || got.found_position !== exp.found_position
            || got.member_count !== exp.member_count
            || got.out_of_range !== exp.out_of_range) begin
            fails++;
            if (fails <= SHOWN_FAILS)
                $display({"bsfn_checker: result %0d mismatch: ",
                          "expected mem=%0b found=%0b pos=%0d cnt=%0d oor=%0b, ",
                          "got mem=%0b found=%0b pos=%0d cnt=%0d oor=%0b"},
                         checked, exp.is_member, exp.found, exp.found_position,
                         exp.member_count, exp.out_of_range, got.is_member, got.found,
                         got.found_position, got.member_count, got.out_of_range);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            member_bits = '0;
            live_count  = '0;
            size_reg    = CFG_RESET;
            due_results.delete();
        end else begin
            if (i_cfg_we)
                size_reg = i_cfg_wdata;
            if (i_out_valid && !i_out_stall)
                check_result(i_out_word);
            if (i_in_valid && !i_in_stall)
                due_results.push_back(apply_request(i_in_word));
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

FILE: tb/sv/tb_top.sv
// testbench top for the bitmap set unit: clock, reset, stimulus and verdict
module tb_top;
    import bsfn_pkg::*;

    localparam int HOLD_CYCLES = 80;   // long receiver hold-off to back up the block
    localparam int TAIL_CYCLES = 20;   // quiet cycles after the last result

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_word         in_word   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [POS_W-1:0] cfg_wdata = CFG_RESET;

    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    int fail_count;
    int pending;
    int checked;

    // stimulus knobs
    bit          in_idle_on  = 1'b1;   // only the stimulus process reads this
    logic        out_idle_on = 1'b1;   // read by the receiver, so changed with nba
    logic        hold_tgl    = 1'b0;   // a toggle asks the receiver for one long hold
    logic        hold_seen   = 1'b0;
    int          hold_left   = 0;
    int unsigned cur_size    = 256;    // effective set size the stimulus aims at
    int          words_sent  = 0;
    int          sizes_used  = 0;

    bitmap_set_with_find_next_unit #(
        .SET_CAPACITY (256)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bsfn_checker #(
        .SET_CAPACITY (256)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // safety net against a hung handshake
    initial begin
        #400000;
        $display("tb_top: FAIL");
        $finish;
    end

    // receiver: random stalls, plus a counted hold when the stimulus toggles hold_tgl
    always @(posedge clk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= out_idle_on && ($urandom_range(0, 99) < 14);
        end
    end

    // offer one request word, with an optional random gap first; returns at acceptance
    task automatic send_word(input t_op op, input int unsigned mem, input int unsigned from);
        t_in_word w;
        w.operation   = op;
        w.member      = mem[7:0];
        w.search_from = from[POS_W-1:0];
        while (in_idle_on && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // percentages for insert, remove and test; the rest are finds
    task automatic send_random(input int ins_pct, input int rem_pct, input int tst_pct);
        int unsigned pick;
        int unsigned mem;
        int unsigned from;
        t_op         op;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct)
            op = OP_INSERT;
        else if (pick < ins_pct + rem_pct)
            op = OP_REMOVE;
        else if (pick < ins_pct + rem_pct + tst_pct)
            op = OP_TEST;
        else
            op = OP_FIND;
        // mostly members inside the set, some anywhere in the 8-bit field
        if (cur_size != 0 && $urandom_range(0, 9) != 0)
            mem = $urandom_range(0, cur_size - 1);
        else
            mem = $urandom_range(0, 255);
        // find starts mostly up to the size, a few anywhere in the 9-bit field
        if ($urandom_range(0, 99) < 85)
            from = $urandom_range(0, cur_size);
        else
            from = $urandom_range(0, 511);
        send_word(op, mem, from);
    endtask

    // stop offering and wait until every expected result word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // register write, only called with the block idle
    task automatic write_size(input int unsigned v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[POS_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_size   = (v > 256) ? 256 : v;
        sizes_used++;
    endtask

    initial begin : stimulus
        int unsigned fill_order [256];
        int unsigned j;
        int unsigned tmp;

        // synchronous reset, held and then released
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset size of 256
        send_word(OP_FIND,   0,   0);     // empty set, nothing to find
        send_word(OP_INSERT, 0,   0);
        send_word(OP_INSERT, 255, 0);
        send_word(OP_INSERT, 0,   0);     // already present, count unchanged
        send_word(OP_TEST,   0,   0);
        send_word(OP_TEST,   255, 511);
        send_word(OP_TEST,   128, 0);     // absent member
        send_word(OP_FIND,   0,   1);     // skips to the top member
        send_word(OP_FIND,   255, 255);
        send_word(OP_FIND,   0,   256);   // start at the size
        send_word(OP_FIND,   0,   511);   // start far beyond the size
        send_word(OP_REMOVE, 255, 0);
        send_word(OP_REMOVE, 255, 0);     // already absent, count unchanged
        send_word(OP_INSERT, 200, 0);
        drain();

        // shrink: member 200 stays stored and counted but is out of reach
        write_size(100);
        send_word(OP_FIND,   0,   1);
        send_word(OP_INSERT, 150, 0);
        send_word(OP_REMOVE, 200, 0);
        send_word(OP_TEST,   99,  0);
        send_word(OP_FIND,   0,   100);
        drain();

        // empty size: every member is out of range
        write_size(0);
        send_word(OP_INSERT, 0, 0);
        send_word(OP_FIND,   0, 0);
        drain();

        // register above the parameter acts as the full size; 200 is visible again
        write_size(511);
        send_word(OP_FIND,   0,   1);
        send_word(OP_REMOVE, 200, 0);
        send_word(OP_REMOVE, 0,   0);
        drain();

        // mixed traffic with one long receiver hold while the sender keeps pushing
        write_size(256);
        for (int i = 0; i < 100; i++) begin
            if (i == 40) begin
                in_idle_on = 1'b0;
                hold_tgl  <= ~hold_tgl;
            end
            if (i == 70)
                in_idle_on = 1'b1;
            send_random(40, 20, 15);
        end
        drain();

        // fill every member in random order, count climbs to 256
        for (int i = 0; i < 256; i++)
            fill_order[i] = i;
        for (int i = 255; i > 0; i--) begin
            j             = $urandom_range(0, i);
            tmp           = fill_order[i];
            fill_order[i] = fill_order[j];
            fill_order[j] = tmp;
        end
        for (int i = 0; i < 256; i++) begin
            send_word(OP_INSERT, fill_order[i], 0);
            if ($urandom_range(0, 7) == 0)
                send_random(0, 0, 40);
        end
        send_word(OP_FIND, 0, 0);
        drain();

        // random smaller size, mostly removes; members above it stay counted
        write_size($urandom_range(1, 255));
        for (int i = 0; i < 100; i++)
            send_random(10, 45, 15);
        drain();

        // size just past one bitmap word
        write_size(33);
        for (int i = 0; i < 80; i++)
            send_random(30, 25, 20);
        drain();

        // single member set
        write_size(1);
        for (int i = 0; i < 20; i++)
            send_random(30, 30, 20);
        drain();

        // full size, no idling on either side, mostly removes
        write_size(256);
        in_idle_on   = 1'b0;
        out_idle_on <= 1'b0;
        for (int i = 0; i < 90; i++)
            send_random(10, 50, 10);
        in_idle_on   = 1'b1;
        out_idle_on <= 1'b1;
        drain();

        // let any stray result word show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("summary: %0d request words sent, %0d result words checked",
                 words_sent, checked);
        $display("summary: %0d size writes incl. 0, 1, 33, 256 and 511, %0d mismatches",
                 sizes_used, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: bitmap_set_with_find_next_unit.f
design/bsfn_pkg.sv
design/bsfn_ram.sv
design/bsfn_scan.sv
design/bitmap_set_with_find_next_unit.sv
tb/sv/bsfn_checker.sv
tb/sv/tb_top.sv
